@@ hw/rtl/i2cm_pkg.sv @@
// Shared types, constants and the pin decode function of the I2C register access master.
// No dependencies; imported by i2cm_wbuf and i2c_register_access_master.
package i2cm_pkg;

    localparam int MAX_BYTES_DEF = 16;

    localparam logic [7:0] DEV_ADDR_RST    = 8'h30;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // Register indexes on the configuration port.
    localparam logic REG_DEVICE_ADDR = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_LOAD  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STG_DEV  = 2'd0,
        STG_REG  = 2'd1,
        STG_DATA = 2'd2
    } t_stage;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_RS_A, PH_ST_B, PH_ST_C,
        PH_TX_SET, PH_TX_HIGH, PH_TX_LOW, PH_AK_LOW, PH_AK_POLL,
        PH_RX_LOW, PH_RX_HIGH, PH_MA_LOW, PH_MA_HIGH,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D
    } t_phase;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_output_enable;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } t_result;

    // Pin levels and flags for one phase. Received bytes and the done flag
    // appear only on tick items.
    function automatic t_result f_emit(t_phase ph, logic [7:0] shift, logic last,
                                       logic tick, logic [2:0] dly, logic failed);
        t_result r;
        r = '{scl_level: 1'b1, sda_drive: 1'b1, sda_output_enable: 1'b1,
              read_valid: 1'b0, read_byte: 8'd0, read_last: 1'b0,
              busy_res: 1'b0, done_res: 1'b0, status: 1'b0};
        unique case (ph)
            PH_RS_A, PH_TX_SET, PH_TX_LOW, PH_SP_A: begin
                r.scl_level = 1'b0;
            end
            PH_AK_LOW, PH_RX_LOW: begin
                r.scl_level         = 1'b0;
                r.sda_output_enable = 1'b0;
            end
            PH_AK_POLL, PH_RX_HIGH: begin
                r.sda_output_enable = 1'b0;
            end
            PH_MA_LOW: begin
                r.scl_level = 1'b0;
                r.sda_drive = last;
                if (tick && dly == 3'd2) begin
                    r.read_valid = 1'b1;
                    r.read_byte  = shift;
                    r.read_last  = last;
                end
            end
            PH_MA_HIGH: begin
                r.sda_drive = last;
            end
            PH_ST_C, PH_SP_C: begin
                r.sda_drive = 1'b0;
            end
            PH_SP_B: begin
                r.scl_level = 1'b0;
                r.sda_drive = 1'b0;
            end
            PH_SP_D: begin
                if (tick && dly <= 3'd1) begin
                    r.done_res = 1'b1;
                    r.status   = failed;
                end
            end
            default: begin
            end
        endcase
        if (ph == PH_TX_SET || ph == PH_TX_HIGH || ph == PH_TX_LOW) begin
            r.sda_drive = shift[7];
        end
        r.busy_res = (ph != PH_IDLE);
        return r;
    endfunction

endpackage

@@ hw/rtl/i2cm_wbuf.sv @@
// Write data buffer of the I2C register access master: one write port, one registered read port.
// Depends on i2cm_pkg for the default depth.
module i2cm_wbuf
    import i2cm_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF,
    parameter int AW        = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [MAX_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A write to the entry being read in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_addr == i_rd_addr) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/i2c_register_access_master.sv @@
// Top level of the I2C register access master: bus sequencer, configuration registers
// and output register. Depends on i2cm_pkg and i2cm_wbuf.
//
//   port group   handshake          contents
//   input item   i_valid / o_ready  i_action, i_sda_level, i_reg_addr, i_byte_count,
//                                   i_write_byte, i_buffer_slot
//   result item  o_valid / i_ready  o_scl_level ... o_status, one result per input item
//   config       psel/penable/...   device_address at 0x0, ack_timeout at 0x4
//
// A new item is accepted in every cycle the output register is empty or being drained.
// The write buffer is read ahead at the index the next acknowledge will need, so its
// registered read port never stalls a tick.
// Reset is synchronous and active low; it returns the sequencer to idle and restores the
// register defaults. A stall on the result side holds the input side through o_ready.
module i2c_register_access_master
    import i2cm_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic        i_sda_level,
    input  logic [7:0]  i_reg_addr,
    input  logic [4:0]  i_byte_count,
    input  logic [7:0]  i_write_byte,
    input  logic [3:0]  i_buffer_slot,

    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_scl_level,
    output logic        o_sda_drive,
    output logic        o_sda_output_enable,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_read_last,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_status,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [8:0] MAX_B9 = 9'(MAX_BYTES);

    // Configuration registers.
    logic [7:0] r_dev_addr;
    logic [7:0] r_ack_timeout;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= DEV_ADDR_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_DEVICE_ADDR) begin
                r_dev_addr <= pwdata[7:0];
            end else begin
                r_ack_timeout <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ACK_TIMEOUT) begin
            prdata = {24'd0, r_ack_timeout};
        end else begin
            prdata = {24'd0, r_dev_addr};
        end
    end

    // Sequencer state.
    t_phase     r_phase, n_phase;
    logic [2:0] r_delay, n_delay;
    logic [3:0] r_bit,   n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_poll,  n_poll;
    logic [4:0] r_idx,   n_idx;
    logic [4:0] r_len,   n_len;
    logic [7:0] r_reg_addr, n_reg_addr;
    logic       r_is_read,  n_is_read;
    t_stage     r_stage,    n_stage;
    logic       r_failed,   n_failed;

    logic       in_acc;
    logic       out_acc;
    t_action    act;
    logic       is_tick;
    logic [7:0] rd_data;
    logic [8:0] rd_idx;
    logic [8:0] slot9;
    logic [4:0] cnt_sat;
    logic       wr_en;

    logic       r_out_valid;
    t_result    r_out;
    t_result    res;

    assign act     = t_action'(i_action);
    assign is_tick = (act == ACT_TICK);
    assign out_acc = r_out_valid && i_ready;
    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    assign slot9   = {5'd0, i_buffer_slot};
    assign wr_en   = in_acc && (act == ACT_LOAD) && (slot9 < MAX_B9);
    assign cnt_sat = ({4'd0, i_byte_count} > MAX_B9) ? MAX_B9[4:0] : i_byte_count;

    // Prefetch the entry the next acknowledge sends: slot 0 after the register address,
    // else the slot after the current one.
    assign rd_idx = (r_stage == STG_REG) ? 9'd0 : ({4'd0, r_idx} + 9'd1);

    i2cm_wbuf #(
        .MAX_BYTES (MAX_BYTES),
        .AW        (AW)
    ) u_wbuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (slot9[AW-1:0]),
        .i_wr_data (i_write_byte),
        .i_rd_addr (rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Next state.
    always_comb begin
        n_phase    = r_phase;
        n_delay    = r_delay;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_poll     = r_poll;
        n_idx      = r_idx;
        n_len      = r_len;
        n_reg_addr = r_reg_addr;
        n_is_read  = r_is_read;
        n_stage    = r_stage;
        n_failed   = r_failed;

        if (is_tick) begin
            if (r_phase == PH_AK_POLL) begin
                if (!i_sda_level) begin
                    n_poll = 8'd0;
                    unique case (r_stage)
                        STG_DEV: begin
                            n_stage = STG_REG;
                            n_shift = r_reg_addr;
                            n_bit   = 4'd0;
                            n_phase = PH_TX_SET;
                            n_delay = 3'd2;
                        end
                        STG_REG: begin
                            n_stage = STG_DATA;
                            n_idx   = 5'd0;
                            n_delay = 3'd2;
                            if (r_is_read) begin
                                n_phase = PH_RS_A;
                            end else if (r_len == 5'd0) begin
                                n_phase = PH_SP_A;
                            end else begin
                                n_shift = rd_data;
                                n_bit   = 4'd0;
                                n_phase = PH_TX_SET;
                            end
                        end
                        default: begin
                            n_delay = 3'd2;
                            if (r_is_read) begin
                                if (r_len == 5'd0) begin
                                    n_phase = PH_SP_A;
                                end else begin
                                    n_shift = 8'd0;
                                    n_bit   = 4'd0;
                                    n_phase = PH_RX_LOW;
                                end
                            end else begin
                                n_idx = r_idx + 5'd1;
                                if ({1'b0, r_idx} + 6'd1 < {1'b0, r_len}) begin
                                    n_shift = rd_data;
                                    n_bit   = 4'd0;
                                    n_phase = PH_TX_SET;
                                end else begin
                                    n_phase = PH_SP_A;
                                end
                            end
                        end
                    endcase
                end else if (r_poll >= r_ack_timeout) begin
                    n_failed = 1'b1;
                    n_phase  = PH_SP_A;
                    n_delay  = 3'd2;
                end else begin
                    n_poll = r_poll + 8'd1;
                end
            end else if (r_phase != PH_IDLE) begin
                if (r_phase == PH_RX_LOW && r_delay == 3'd2) begin
                    n_shift = {r_shift[6:0], i_sda_level};
                end
                if (r_delay > 3'd1) begin
                    n_delay = r_delay - 3'd1;
                end else begin
                    unique case (r_phase)
                        PH_ST_A, PH_RS_A: begin
                            n_phase = PH_ST_B;
                            n_delay = 3'd4;
                        end
                        PH_ST_B: begin
                            n_phase = PH_ST_C;
                            n_delay = 3'd4;
                        end
                        PH_ST_C: begin
                            n_shift = (r_stage == STG_DEV) ? r_dev_addr : (r_dev_addr + 8'd1);
                            n_bit   = 4'd0;
                            n_phase = PH_TX_SET;
                            n_delay = 3'd2;
                        end
                        PH_TX_SET: begin
                            n_phase = PH_TX_HIGH;
                            n_delay = 3'd2;
                        end
                        PH_TX_HIGH: begin
                            n_phase = PH_TX_LOW;
                            n_delay = 3'd2;
                        end
                        PH_TX_LOW: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = r_bit + 4'd1;
                            if (r_bit + 4'd1 >= 4'd8) begin
                                n_phase = PH_AK_LOW;
                                n_delay = 3'd1;
                            end else begin
                                n_phase = PH_TX_SET;
                                n_delay = 3'd2;
                            end
                        end
                        PH_AK_LOW: begin
                            n_poll  = 8'd0;
                            n_phase = PH_AK_POLL;
                            n_delay = 3'd1;
                        end
                        PH_RX_LOW: begin
                            n_phase = PH_RX_HIGH;
                            n_delay = 3'd2;
                        end
                        PH_RX_HIGH: begin
                            n_bit   = r_bit + 4'd1;
                            n_delay = 3'd2;
                            n_phase = (r_bit + 4'd1 >= 4'd8) ? PH_MA_LOW : PH_RX_LOW;
                        end
                        PH_MA_LOW: begin
                            n_phase = PH_MA_HIGH;
                            n_delay = 3'd2;
                        end
                        PH_MA_HIGH: begin
                            n_idx   = r_idx + 5'd1;
                            n_delay = 3'd2;
                            if ({1'b0, r_idx} + 6'd1 < {1'b0, r_len}) begin
                                n_shift = 8'd0;
                                n_bit   = 4'd0;
                                n_phase = PH_RX_LOW;
                            end else begin
                                n_phase = PH_SP_A;
                            end
                        end
                        PH_SP_A: begin
                            n_phase = PH_SP_B;
                            n_delay = 3'd4;
                        end
                        PH_SP_B: begin
                            n_phase = PH_SP_C;
                            n_delay = 3'd2;
                        end
                        PH_SP_C: begin
                            n_phase = PH_SP_D;
                            n_delay = 3'd4;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_delay = 3'd0;
                        end
                    endcase
                end
            end
        end else if (act != ACT_LOAD && r_phase == PH_IDLE) begin
            n_reg_addr = i_reg_addr;
            n_len      = cnt_sat;
            n_is_read  = (act == ACT_READ);
            n_stage    = STG_DEV;
            n_idx      = 5'd0;
            n_poll     = 8'd0;
            n_failed   = 1'b0;
            n_bit      = 4'd0;
            n_shift    = 8'd0;
            n_phase    = PH_ST_A;
            n_delay    = 3'd2;
        end
    end

    // Result of the item: a tick shows the phase it spends, a command the phase it leads to.
    always_comb begin
        if (is_tick) begin
            res = f_emit(r_phase, r_shift, ({1'b0, r_idx} + 6'd1 >= {1'b0, r_len}),
                         1'b1, r_delay, r_failed);
        end else begin
            res = f_emit(n_phase, n_shift, ({1'b0, n_idx} + 6'd1 >= {1'b0, n_len}),
                         1'b0, n_delay, n_failed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_delay    <= 3'd0;
            r_bit      <= 4'd0;
            r_shift    <= 8'd0;
            r_poll     <= 8'd0;
            r_idx      <= 5'd0;
            r_len      <= 5'd0;
            r_reg_addr <= 8'd0;
            r_is_read  <= 1'b0;
            r_stage    <= STG_DEV;
            r_failed   <= 1'b0;
        end else if (in_acc) begin
            r_phase    <= n_phase;
            r_delay    <= n_delay;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_poll     <= n_poll;
            r_idx      <= n_idx;
            r_len      <= n_len;
            r_reg_addr <= n_reg_addr;
            r_is_read  <= n_is_read;
            r_stage    <= n_stage;
            r_failed   <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= res;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_scl_level         = r_out.scl_level;
    assign o_sda_drive         = r_out.sda_drive;
    assign o_sda_output_enable = r_out.sda_output_enable;
    assign o_read_valid        = r_out.read_valid;
    assign o_read_byte         = r_out.read_byte;
    assign o_read_last         = r_out.read_last;
    assign o_busy_res          = r_out.busy_res;
    assign o_done_res          = r_out.done_res;
    assign o_status            = r_out.status;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> r_out.busy_res)
        else $error("done reported outside a transfer");

    a_rx_scl_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.read_valid |-> !r_out.scl_level && r_out.sda_output_enable)
        else $error("received byte shown outside the acknowledge slot");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 4'd8)
        else $error("bit counter overran a byte");

    a_idle_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_delay == 3'd0)
        else $error("delay count left over in idle");

    a_poll_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_tick && r_phase == PH_AK_POLL && i_sda_level
        && r_poll >= r_ack_timeout |=> r_phase == PH_SP_A && r_failed)
        else $error("acknowledge timeout did not start the stop");

endmodule
